// ----- hw/rtl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int STAT_W = 2;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_code_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PUSH_FIRST,
		OP_PUSH_PRIME,
		OP_SHIFT_MOVE,
		OP_SHIFT_PLACE,
		OP_FILL0,
		OP_POP,
		OP_POP_READ,
		OP_OVF,
		OP_UDF,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic mode;
		logic empty;
		logic full;
		logic one;
		logic ge;
		logic ptr_zero;
		logic out_free;
	} dp_status_t;

endpackage

// ----- hw/rtl/spq_ram.sv -----
// generic single-write, single-read ram with registered read data
module spq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- hw/rtl/spq_ctrl.sv -----
// controller state machine sequencing push, pop and result delivery
module spq_ctrl
	import spq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  dp_status_t sts,
	output dp_op_t     op
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_FILL0,
		S_POPRD,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		op      = OP_NONE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op      = OP_LOAD;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!sts.mode) begin
					if (sts.full) begin
						op      = OP_OVF;
						state_d = S_DONE;
					end else if (sts.empty) begin
						op      = OP_PUSH_FIRST;
						state_d = S_DONE;
					end else begin
						op      = OP_PUSH_PRIME;
						state_d = S_SHIFT;
					end
				end else begin
					if (sts.empty) begin
						op      = OP_UDF;
						state_d = S_DONE;
					end else begin
						op      = OP_POP;
						state_d = sts.one ? S_DONE : S_POPRD;
					end
				end
			end
			S_SHIFT: begin
				if (sts.ge) begin
					op      = OP_SHIFT_MOVE;
					state_d = sts.ptr_zero ? S_FILL0 : S_SHIFT;
				end else begin
					op      = OP_SHIFT_PLACE;
					state_d = S_DONE;
				end
			end
			S_FILL0: begin
				op      = OP_FILL0;
				state_d = S_DONE;
			end
			S_POPRD: begin
				op      = OP_POP_READ;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					op      = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/spq_dp.sv -----
// datapath: entry memory, count, top register, scan pointer and result register
module spq_dp
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_op_t            op,
	output dp_status_t        sts,
	input  logic              req_mode,
	input  logic [DATA_W-1:0] req_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_top,
	output logic              out_empty,
	output logic [STAT_W-1:0] out_status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]            count_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] val_q;
	logic                     mode_q;
	status_code_t             status_q;
	logic [AW-1:0]            ptr_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_top_q;
	logic                     out_empty_q;
	logic [STAT_W-1:0]        out_status_q;

	logic [CW-1:0]            cnt_m1;
	logic [CW-1:0]            cnt_m2;
	logic [AW-1:0]            ptr_p1;
	logic [AW-1:0]            ptr_m1;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [DATA_W-1:0]        wr_data;
	logic [AW-1:0]            rd_addr;
	logic [DATA_W-1:0]        rd_data;
	logic                     out_free;

	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);
	assign ptr_p1   = ptr_q + AW'(1);
	assign ptr_m1   = ptr_q - AW'(1);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = val_q;
		rd_addr = cnt_m1[AW-1:0];
		case (op)
			OP_PUSH_FIRST: begin
				wr_en = 1'b1;
			end
			OP_SHIFT_MOVE: begin
				wr_en   = 1'b1;
				wr_addr = ptr_p1;
				wr_data = rd_data;
				rd_addr = ptr_m1;
			end
			OP_SHIFT_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = ptr_p1;
			end
			OP_FILL0: begin
				wr_en = 1'b1;
			end
			OP_POP: begin
				rd_addr = cnt_m2[AW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	spq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		sts.mode     = mode_q;
		sts.empty    = (count_q == '0);
		sts.full     = (count_q == CW'(CAPACITY));
		sts.one      = (count_q == CW'(1));
		sts.ge       = ($signed(rd_data) >= val_q);
		sts.ptr_zero = (ptr_q == '0);
		sts.out_free = out_free;
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				mode_q <= req_mode;
				val_q  <= $signed(req_value);
			end
			OP_PUSH_FIRST: begin
				top_q <= val_q;
			end
			OP_PUSH_PRIME: begin
				ptr_q <= cnt_m1[AW-1:0];
				if (val_q > top_q) begin
					top_q <= val_q;
				end
			end
			OP_SHIFT_MOVE: begin
				ptr_q <= ptr_m1;
			end
			OP_POP_READ: begin
				top_q <= $signed(rd_data);
			end
			OP_EMIT: begin
				out_top_q    <= (count_q == '0) ? {DATA_W{1'b1}} : top_q;
				out_empty_q  <= (count_q == '0);
				out_status_q <= status_q;
			end
			default: begin
				ptr_q <= ptr_q;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			case (op)
				OP_LOAD:       status_q <= ST_OK;
				OP_OVF:        status_q <= ST_OVERFLOW;
				OP_UDF:        status_q <= ST_UNDERFLOW;
				OP_PUSH_FIRST: count_q  <= count_q + CW'(1);
				OP_PUSH_PRIME: count_q  <= count_q + CW'(1);
				OP_POP:        count_q  <= cnt_m1;
				default:       count_q  <= count_q;
			endcase
			if (op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_top    = out_top_q;
	assign out_empty  = out_empty_q;
	assign out_status = out_status_q;

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
// sorted max-priority queue top level: controller, datapath and stream ports
// push to an empty queue writes directly; else a ram scan from the top moves up each
// held entry not smaller than the value, then places it; pop reloads the top from ram
// unless one remains; full or empty are rejected; one request at a time, the input
// being registered on acceptance; the next request is taken while the result waits
// reset clears the count, status and result valid; entry ram is not cleared
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value
	input  logic        s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // top_value
	output logic [2:0]  m_tuser   // status[1:0], is_empty
);

	dp_op_t     op;
	dp_status_t sts;
	logic       out_empty;
	logic [1:0] out_status;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.sts       (sts),
		.op        (op)
	);

	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.sts        (sts),
		.req_mode   (s_tuser),
		.req_value  (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_top    (m_tdata),
		.out_empty  (out_empty),
		.out_status (out_status)
	);

	assign m_tuser = {out_status, out_empty};

endmodule
